// File: sv/svbe_pkg.sv
// Shared types and constants for the sparse voxel brick expander.
`timescale 1ns / 1ps
`default_nettype none

package svbe_pkg;

  localparam int INDEX_W    = 24;  // brick_index and start_offset field width
  localparam int MASK_W     = 64;  // voxels in one 4x4x4 brick
  localparam int BIT_W      = 6;   // local voxel number width
  localparam int GRID_W     = 13;
  localparam int OFFSET_W   = 21;
  localparam int SLEN_W     = 25;
  localparam int COORD_W    = 28;
  localparam int DATA_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam logic [DATA_W-1:0] DATA_MAX = 24'hFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_X   = 3'd0,
    REG_GRID_Y   = 3'd1,
    REG_OFFSET_X = 3'd2,
    REG_OFFSET_Y = 3'd3,
    REG_OFFSET_Z = 3'd4,
    REG_STREAM   = 3'd5
  } cfg_reg_t;

  // Configuration as seen by the datapath; grid sizes already mapped 0 -> 1.
  typedef struct packed {
    logic        [GRID_W-1:0]   gx;
    logic        [GRID_W-1:0]   gy;
    logic signed [OFFSET_W-1:0] ox;
    logic signed [OFFSET_W-1:0] oy;
    logic signed [OFFSET_W-1:0] oz;
    logic        [SLEN_W-1:0]   slen;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV_X,
    ST_DIV_Y,
    ST_BASE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic load;        // capture input item
    logic div_start;   // launch a division
    logic div_sel;     // 0: index / gx, 1: quotient / gy
    logic latch_x;     // keep remainder as brick x
    logic latch_yz;    // keep remainder as brick y, quotient as brick z
    logic base_load;   // form world base coordinates
    logic step;        // advance scan by one mask bit
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mask_empty;
    logic bit_set;
    logic out_free;
    logic trunc;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: sv/svbe_in_if.sv
// Input channel carrying one sparse brick record per item.
`timescale 1ns / 1ps
`default_nettype none

interface svbe_in_if;
  logic                             valid;
  logic                             ready;
  logic [svbe_pkg::INDEX_W-1:0]     brick_index;
  logic [svbe_pkg::MASK_W-1:0]      occupancy_mask;
  logic [svbe_pkg::INDEX_W-1:0]     start_offset;

  modport source (output valid, output brick_index, output occupancy_mask,
                  output start_offset, input ready);
  modport sink   (input valid, input brick_index, input occupancy_mask,
                  input start_offset, output ready);
endinterface

`default_nettype wire

// File: sv/svbe_out_if.sv
// Result channel carrying one expanded voxel per item.
`timescale 1ns / 1ps
`default_nettype none

interface svbe_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [svbe_pkg::COORD_W-1:0] voxel_x;
  logic signed [svbe_pkg::COORD_W-1:0] voxel_y;
  logic signed [svbe_pkg::COORD_W-1:0] voxel_z;
  logic        [svbe_pkg::DATA_W-1:0]  data_index;
  logic                                last;
  logic                                truncated;

  modport source (output valid, output voxel_x, output voxel_y, output voxel_z,
                  output data_index, output last, output truncated, input ready);
  modport sink   (input valid, input voxel_x, input voxel_y, input voxel_z,
                  input data_index, input last, input truncated, output ready);
endinterface

`default_nettype wire

// File: sv/svbe_cfg_if.sv
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
`default_nettype none

interface svbe_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [svbe_pkg::CFG_IDX_W-1:0]     index;
  logic [svbe_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/svbe_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module svbe_div #(
  parameter int DIVIDEND_W = 24,
  parameter int DIVISOR_W  = 13
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient,
  output logic [DIVISOR_W-1:0]       remainder
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dvs_r;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;
  logic [DIVISOR_W-1:0]  rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[DIVIDEND_W-1]};
    ge      = (trial >= {1'b0, dvs_r});
    diff    = trial - {1'b0, dvs_r};
    rem_nxt = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVIDEND_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out of the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVIDEND_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// File: sv/svbe_cfg.sv
// Configuration register file with grid size normalization.
`timescale 1ns / 1ps
`default_nettype none

module svbe_cfg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  svbe_cfg_if.sink        cfg_ch,
  output svbe_pkg::cfg_t  cfg
);

  logic        [svbe_pkg::GRID_W-1:0]   gx_r;
  logic        [svbe_pkg::GRID_W-1:0]   gy_r;
  logic signed [svbe_pkg::OFFSET_W-1:0] ox_r;
  logic signed [svbe_pkg::OFFSET_W-1:0] oy_r;
  logic signed [svbe_pkg::OFFSET_W-1:0] oz_r;
  logic        [svbe_pkg::SLEN_W-1:0]   slen_r;

  // Hold off writes while reset is applied.
  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gx_r   <= svbe_pkg::GRID_W'(1);
      gy_r   <= svbe_pkg::GRID_W'(1);
      ox_r   <= '0;
      oy_r   <= '0;
      oz_r   <= '0;
      slen_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (svbe_pkg::cfg_reg_t'(cfg_ch.index))
        svbe_pkg::REG_GRID_X:   gx_r   <= cfg_ch.data[svbe_pkg::GRID_W-1:0];
        svbe_pkg::REG_GRID_Y:   gy_r   <= cfg_ch.data[svbe_pkg::GRID_W-1:0];
        svbe_pkg::REG_OFFSET_X: ox_r   <= cfg_ch.data[svbe_pkg::OFFSET_W-1:0];
        svbe_pkg::REG_OFFSET_Y: oy_r   <= cfg_ch.data[svbe_pkg::OFFSET_W-1:0];
        svbe_pkg::REG_OFFSET_Z: oz_r   <= cfg_ch.data[svbe_pkg::OFFSET_W-1:0];
        svbe_pkg::REG_STREAM:   slen_r <= cfg_ch.data[svbe_pkg::SLEN_W-1:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // A zero grid size counts as one brick.
  always_comb begin
    cfg.gx   = (gx_r == '0) ? svbe_pkg::GRID_W'(1) : gx_r;
    cfg.gy   = (gy_r == '0) ? svbe_pkg::GRID_W'(1) : gy_r;
    cfg.ox   = ox_r;
    cfg.oy   = oy_r;
    cfg.oz   = oz_r;
    cfg.slen = slen_r;
  end

endmodule

`default_nettype wire

// File: sv/svbe_ctrl.sv
// Controller state machine sequencing division, base setup and mask scan.
`timescale 1ns / 1ps
`default_nettype none

module svbe_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire svbe_pkg::dp_stat_t  stat,
  output svbe_pkg::dp_cmd_t        cmd
);

  svbe_pkg::state_t state_r;
  svbe_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= svbe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      svbe_pkg::ST_IDLE: begin
        in_ready = rst_n;
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = svbe_pkg::ST_START;
        end
      end
      svbe_pkg::ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = svbe_pkg::ST_DIV_X;
      end
      svbe_pkg::ST_DIV_X: begin
        if (stat.div_done) begin
          cmd.latch_x   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_nxt     = svbe_pkg::ST_DIV_Y;
        end
      end
      svbe_pkg::ST_DIV_Y: begin
        if (stat.div_done) begin
          cmd.latch_yz = 1'b1;
          state_nxt    = svbe_pkg::ST_BASE;
        end
      end
      svbe_pkg::ST_BASE: begin
        cmd.base_load = 1'b1;
        state_nxt     = svbe_pkg::ST_SCAN;
      end
      svbe_pkg::ST_SCAN: begin
        priority if (stat.mask_empty) begin
          state_nxt = svbe_pkg::ST_IDLE;
        end else if (!stat.bit_set) begin
          cmd.step = 1'b1;
        end else if (stat.out_free) begin
          // a truncated item ends the run
          cmd.step = 1'b1;
          if (stat.trunc) begin
            state_nxt = svbe_pkg::ST_IDLE;
          end
        end else begin
          // hold on this bit until the output register frees up
          cmd.step = 1'b0;
        end
      end
      default: state_nxt = svbe_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/svbe_dp.sv
// Datapath: brick index split, base coordinates, mask scan and output register.
`timescale 1ns / 1ps
`default_nettype none

module svbe_dp #(
  parameter int INDEX_BITS = 24
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire svbe_pkg::cfg_t                      cfg,
  input  wire svbe_pkg::dp_cmd_t                   cmd,
  output svbe_pkg::dp_stat_t                       stat,
  input  wire logic [svbe_pkg::INDEX_W-1:0]        brick_index,
  input  wire logic [svbe_pkg::MASK_W-1:0]         occupancy_mask,
  input  wire logic [svbe_pkg::INDEX_W-1:0]        start_offset,
  svbe_out_if.source                               out_ch
);

  localparam int CW = svbe_pkg::COORD_W;
  localparam int GW = svbe_pkg::GRID_W;
  localparam int SW = svbe_pkg::SLEN_W;
  localparam int DW = svbe_pkg::DATA_W;
  localparam int MW = svbe_pkg::MASK_W;
  localparam int BW = svbe_pkg::BIT_W;

  logic [INDEX_BITS-1:0] idx_r;
  logic [MW-1:0]         mask_r;
  logic [SW-1:0]         data_r;
  logic [BW-1:0]         bit_r;
  logic [GW-1:0]         bx_r;
  logic [GW-1:0]         by_r;
  logic [INDEX_BITS-1:0] bz_r;
  logic [CW-1:0]         base_x_r;
  logic [CW-1:0]         base_y_r;
  logic [CW-1:0]         base_z_r;

  logic                  out_valid_r;
  logic [CW-1:0]         out_x_r;
  logic [CW-1:0]         out_y_r;
  logic [CW-1:0]         out_z_r;
  logic [DW-1:0]         out_data_r;
  logic                  out_last_r;
  logic                  out_trunc_r;

  logic [INDEX_BITS-1:0] div_dividend;
  logic [GW-1:0]         div_divisor;
  logic                  div_done;
  logic [INDEX_BITS-1:0] div_quo;
  logic [GW-1:0]         div_rem;

  logic                  emit;
  logic                  trunc;
  logic                  out_free;
  logic [DW-1:0]         sat_data;

  assign div_dividend = cmd.div_sel ? div_quo : idx_r;
  assign div_divisor  = cmd.div_sel ? cfg.gy  : cfg.gx;

  // x = i mod gx, then y and z from (i / gx) divided by gy
  svbe_div #(
    .DIVIDEND_W (INDEX_BITS),
    .DIVISOR_W  (GW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign trunc    = (data_r >= cfg.slen);
  assign out_free = !out_valid_r || out_ch.ready;
  assign emit     = cmd.step && mask_r[0];
  assign sat_data = (data_r > SW'(svbe_pkg::DATA_MAX)) ? svbe_pkg::DATA_MAX : data_r[DW-1:0];

  always_comb begin
    stat.div_done   = div_done;
    stat.mask_empty = (mask_r == '0);
    stat.bit_set    = mask_r[0];
    stat.out_free   = out_free;
    stat.trunc      = trunc;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r  <= brick_index[INDEX_BITS-1:0];
      mask_r <= occupancy_mask;
      data_r <= SW'(start_offset);
      bit_r  <= '0;
    end else if (cmd.step) begin
      mask_r <= {1'b0, mask_r[MW-1:1]};
      bit_r  <= bit_r + BW'(1);
      if (mask_r[0]) begin
        data_r <= data_r + SW'(1);
      end
    end
    if (cmd.latch_x) begin
      bx_r <= div_rem;
    end
    if (cmd.latch_yz) begin
      by_r <= div_rem;
      bz_r <= div_quo;
    end
    if (cmd.base_load) begin
      base_x_r <= CW'({bx_r, 2'b00}) + CW'(cfg.ox);
      base_y_r <= CW'({by_r, 2'b00}) + CW'(cfg.oy);
      base_z_r <= CW'({bz_r, 2'b00}) + CW'(cfg.oz);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (trunc) begin
        out_x_r     <= '0;
        out_y_r     <= '0;
        out_z_r     <= '0;
        out_data_r  <= sat_data;
        out_last_r  <= 1'b1;
        out_trunc_r <= 1'b1;
      end else begin
        out_x_r     <= base_x_r + CW'(bit_r[1:0]);
        out_y_r     <= base_y_r + CW'(bit_r[3:2]);
        out_z_r     <= base_z_r + CW'(bit_r[5:4]);
        out_data_r  <= data_r[DW-1:0];
        out_last_r  <= (mask_r[MW-1:1] == '0);
        out_trunc_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.voxel_x    = out_x_r;
  assign out_ch.voxel_y    = out_y_r;
  assign out_ch.voxel_z    = out_z_r;
  assign out_ch.data_index = out_data_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.truncated  = out_trunc_r;

endmodule

`default_nettype wire

// File: sv/sparse_voxel_brick_expand.sv
// Top level of the sparse voxel brick expander.
//
// in_ch takes one brick record: linear brick index, 64-bit occupancy mask and
// the start offset of the brick's packed voxel words. out_ch gives one item per
// set mask bit, lowest bit first, with world voxel x/y/z, data index and a last
// flag on the final item of the run. A data index at or past the stream length
// gives one item with truncated and last set, and the run stops there.
// cfg_ch writes grid size, region offsets and stream length; the user must
// write them only while idle, as the block itself does not enforce this.
// The brick index is split by one shared restoring divider run twice, then
// base coordinates are formed and the scan steps through the mask bits up to
// the highest set bit, then returns to idle, where the next record is taken.
// Each result sits in an output register; while out_ch stalls, the scan holds
// on the next set bit.
// Reset restores grid 1x1, zero offsets and zero stream length, and empties
// the output register; in_ch and cfg_ch stay not ready while reset is held.
`timescale 1ns / 1ps
`default_nettype none

module sparse_voxel_brick_expand #(
  parameter int INDEX_BITS = 24
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  svbe_in_if.sink      in_ch,
  svbe_out_if.source   out_ch,
  svbe_cfg_if.sink     cfg_ch
);

  svbe_pkg::cfg_t     cfg;
  svbe_pkg::dp_cmd_t  cmd;
  svbe_pkg::dp_stat_t stat;
  logic               in_ready;

  assign in_ch.ready = in_ready;

  svbe_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  svbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  svbe_dp #(
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd            (cmd),
    .stat           (stat),
    .brick_index    (in_ch.brick_index),
    .occupancy_mask (in_ch.occupancy_mask),
    .start_offset   (in_ch.start_offset),
    .out_ch         (out_ch)
  );

endmodule

`default_nettype wire
